// ===== rtl/rmmv_pkg.sv =====
// ----------------------------------------------------------------------------
// rmmv_pkg
// Types and constants for the running min/max/mean/variance core.
// ----------------------------------------------------------------------------
package rmmv_pkg;

  localparam int unsigned CountW = 32;
  localparam int unsigned SampW  = 32;
  localparam int unsigned MeanW  = 48;
  localparam int unsigned VarW   = 64;
  // dividend / accumulator width: (n-1)*var plus truncated product
  localparam int unsigned AccW   = 97;

  localparam logic [CountW-1:0] CountMax = '1;

  // one channel's statistics record
  typedef struct packed {
    logic [CountW-1:0] count;
    logic [SampW-1:0]  min_v;
    logic [SampW-1:0]  max_v;
    logic [MeanW-1:0]  mean;
    logic [VarW-1:0]   var_v;
  } stat_rec_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_MEAN,
    S_MUL,
    S_VSET,
    S_WB
  } stat_state_t;

endpackage

// ===== rtl/rmmv_if.sv =====
// ----------------------------------------------------------------------------
// rmmv_in_if / rmmv_out_if
// Valid/ready channels for samples and statistics results.
// ----------------------------------------------------------------------------
interface rmmv_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  channel;
  logic        restart;
  logic [31:0] sample_value;

  modport source (output valid, channel, restart, sample_value, input ready);
  modport sink   (input valid, channel, restart, sample_value, output ready);
endinterface

interface rmmv_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  out_channel;
  logic [31:0] sample_count;
  logic [31:0] min_value;
  logic [31:0] max_value;
  logic [47:0] mean_value;
  logic [63:0] variance_value;

  modport source (output valid, out_channel, sample_count, min_value, max_value,
                  mean_value, variance_value, input ready);
  modport sink   (input valid, out_channel, sample_count, min_value, max_value,
                  mean_value, variance_value, output ready);
endinterface

// ===== rtl/running_min_max_mean_variance_core.sv =====
// From accepted sample to result: one record read, a 48-step mean division,
// seven multiply/accumulate steps and a 97-step variance division through one
// shared restoring divider (one bit a cycle), then write-back to the output.
// Out-of-range channel: straight to write-back, zero record. One sample in flight.
// Reset (rst, synchronous): per-channel valid bits cleared, so every record
// reads as zero; no clearing pass.
// ----------------------------------------------------------------------------
// running_min_max_mean_variance_core
// Per-channel count, min, max, Welford mean and variance kept in one record
// memory, updated read-modify-write by a sequencer with a shared divider.
// ----------------------------------------------------------------------------
module running_min_max_mean_variance_core import rmmv_pkg::*; #(
  parameter int unsigned CHANNELS = 16
) (
  input  logic        clk,
  input  logic        rst,
  rmmv_in_if.sink     sample_in,
  rmmv_out_if.source  result_out
);

  localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  stat_state_t state, state_next;

  // record memory and per-entry valid bits
  stat_rec_t          mem [CHANNELS];
  logic [CHANNELS-1:0] vld;
  stat_rec_t          rd_q;
  logic               rd_vld;

  // latched transaction
  logic [3:0]    ch;
  logic [AW-1:0] addr;
  logic          restart;
  logic          oor;
  logic [31:0]   x;

  // working values
  logic [CountW-1:0] n;
  logic [SampW-1:0]  min_r, max_r;
  logic [MeanW-1:0]  m_old, m_new, a1, a2;
  logic [VarW-1:0]   var_old;
  logic              up;

  // divider
  logic [AccW-1:0] dvd, quo;
  logic [31:0]     rem;
  logic [6:0]      dcnt;
  logic            dsel;   // 0: mean quotient, 1: variance quotient

  // multiplier / accumulator
  logic [2:0]      step;
  logic [63:0]     prod;
  logic [AccW-1:0] acc;

  // output register
  logic        ovalid;
  logic [3:0]  o_ch;
  stat_rec_t   o_rec;

  logic [8:0]  in_ch_ext;
  logic [AW-1:0] in_addr;
  logic        in_acc, out_free;

  assign in_ch_ext = {5'b0, sample_in.channel};
  assign in_addr   = in_ch_ext[AW-1:0];
  assign in_acc    = sample_in.valid && sample_in.ready;
  assign out_free  = !ovalid || result_out.ready;
  assign sample_in.ready = (state == S_IDLE);

  // load-stage combinational prep
  stat_rec_t         cur;
  logic [CountW-1:0] n_c;
  logic [SampW-1:0]  min_c, max_c;
  logic [MeanW-1:0]  xq, a1_c;
  logic              up_c;

  always_comb begin
    cur = (rd_vld && !restart) ? rd_q : '0;
    if (cur.count == '0) begin
      min_c = x;
      max_c = x;
    end else begin
      min_c = (x < cur.min_v) ? x : cur.min_v;
      max_c = (x > cur.max_v) ? x : cur.max_v;
    end
    n_c  = (cur.count == CountMax) ? cur.count : cur.count + 1'b1;
    xq   = {x, 16'h0};
    up_c = (xq >= cur.mean);
    a1_c = up_c ? xq - cur.mean : cur.mean - xq;
  end

  // mean update from the divider quotient
  logic [MeanW-1:0] m_new_c, a2_c;
  always_comb begin
    m_new_c = up ? m_old + quo[MeanW-1:0] : m_old - quo[MeanW-1:0];
    a2_c    = up ? {x, 16'h0} - m_new_c : m_new_c - {x, 16'h0};
  end

  // divider step
  logic [32:0] rsh, rdiff;
  logic        qbit;
  always_comb begin
    rsh   = {rem, dvd[AccW-1]};
    rdiff = rsh - {1'b0, n};
    qbit  = (rsh >= {1'b0, n});
  end

  // multiplier operand select
  logic [31:0] op_a, op_b;
  logic [CountW-1:0] nm1;
  assign nm1 = n - 1'b1;
  always_comb begin
    unique case (step)
      3'd0:    begin op_a = a1[31:0];           op_b = a2[31:0];           end
      3'd1:    begin op_a = a1[31:0];           op_b = {16'h0, a2[47:32]}; end
      3'd2:    begin op_a = {16'h0, a1[47:32]}; op_b = a2[31:0];           end
      3'd3:    begin op_a = {16'h0, a1[47:32]}; op_b = {16'h0, a2[47:32]}; end
      3'd4:    begin op_a = nm1;                op_b = var_old[31:0];      end
      default: begin op_a = nm1;                op_b = var_old[63:32];     end
    endcase
  end

  // accumulate the product issued one step earlier
  logic [AccW-1:0] acc_c, p_ext;
  always_comb begin
    p_ext = {{(AccW-64){1'b0}}, prod};
    unique case (step)
      3'd1:    acc_c = acc + p_ext;
      3'd2,
      3'd3:    acc_c = acc + (p_ext << 32);
      3'd4:    acc_c = (acc + (p_ext << 64)) >> 32;
      3'd5:    acc_c = acc + p_ext;
      3'd6:    acc_c = acc + (p_ext << 32);
      default: acc_c = acc;
    endcase
  end

  // result record
  stat_rec_t wb_rec;
  always_comb begin
    wb_rec.count = n;
    wb_rec.min_v = min_r;
    wb_rec.max_v = max_r;
    wb_rec.mean  = m_new;
    wb_rec.var_v = (quo[AccW-1:VarW] != '0) ? '1 : quo[VarW-1:0];
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_acc) state_next = (in_ch_ext >= 9'(CHANNELS)) ? S_WB : S_LOAD;
      S_LOAD: state_next = S_DIV;
      S_DIV:  if (dcnt == 7'd1) state_next = dsel ? S_WB : S_MEAN;
      S_MEAN: state_next = S_MUL;
      S_MUL:  if (step == 3'd6) state_next = S_VSET;
      S_VSET: state_next = S_DIV;
      S_WB:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // record memory: registered read at accept, write at write-back
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_acc) rd_q <= mem[in_addr];
    if (state == S_WB && out_free && !oor) mem[addr] <= wb_rec;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (state == S_IDLE && in_acc) rd_vld <= vld[in_addr];
      if (state == S_WB && out_free && !oor) vld[addr] <= 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          ch      <= sample_in.channel;
          addr    <= in_addr;
          restart <= sample_in.restart;
          x       <= sample_in.sample_value;
          oor     <= (in_ch_ext >= 9'(CHANNELS));
        end
      end
      S_LOAD: begin
        n       <= n_c;
        min_r   <= min_c;
        max_r   <= max_c;
        m_old   <= cur.mean;
        var_old <= cur.var_v;
        up      <= up_c;
        a1      <= a1_c;
        dvd     <= {a1_c, {(AccW-MeanW){1'b0}}};
        rem     <= '0;
        quo     <= '0;
        dcnt    <= 7'(MeanW);
        dsel    <= 1'b0;
      end
      S_DIV: begin
        dvd  <= dvd << 1;
        rem  <= qbit ? rdiff[31:0] : rsh[31:0];
        quo  <= {quo[AccW-2:0], qbit};
        dcnt <= dcnt - 1'b1;
      end
      S_MEAN: begin
        m_new <= m_new_c;
        a2    <= a2_c;
        acc   <= '0;
        step  <= '0;
      end
      S_MUL: begin
        prod <= op_a * op_b;
        acc  <= acc_c;
        step <= step + 1'b1;
      end
      S_VSET: begin
        dvd  <= acc;
        rem  <= '0;
        quo  <= '0;
        dcnt <= 7'(AccW);
        dsel <= 1'b1;
      end
      S_WB: ;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (state == S_WB && out_free) begin
      ovalid <= 1'b1;
    end else if (result_out.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_WB && out_free) begin
      o_ch  <= ch;
      o_rec <= oor ? '0 : wb_rec;
    end
  end

  assign result_out.valid          = ovalid;
  assign result_out.out_channel    = o_ch;
  assign result_out.sample_count   = o_rec.count;
  assign result_out.min_value      = o_rec.min_v;
  assign result_out.max_value      = o_rec.max_v;
  assign result_out.mean_value     = o_rec.mean;
  assign result_out.variance_value = o_rec.var_v;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for running_min_max_mean_variance_core. A directed table
// of samples, then random series on all channels, with random gaps and stalls
// on both channels. Each result is checked against a bit-exact predictor of
// the per-channel Welford statistics.
// ----------------------------------------------------------------------------
module testbench import rmmv_pkg::*; ();

  localparam int NumChan    = 16;
  localparam int RandItems  = 1430;
  localparam int DrainWait  = 400;

  typedef struct packed {
    logic [3:0]        ch;
    logic [CountW-1:0] count;
    logic [SampW-1:0]  min_v;
    logic [SampW-1:0]  max_v;
    logic [MeanW-1:0]  mean;
    logic [VarW-1:0]   var_v;
  } stat_result_t;

  typedef struct packed {
    logic [3:0]   ch;
    logic         rs;
    logic [31:0]  x;
    logic         typed;
    stat_result_t exp;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors = 0;
  bit   calm = 1'b0;

  rmmv_in_if  sample_in ();
  rmmv_out_if result_out ();

  running_min_max_mean_variance_core #(.CHANNELS(NumChan)) u_top (
    .clk        (clk),
    .rst        (rst),
    .sample_in  (sample_in),
    .result_out (result_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the channel records
  logic [CountW-1:0] cnt_q  [NumChan];
  logic [SampW-1:0]  min_q  [NumChan];
  logic [SampW-1:0]  max_q  [NumChan];
  logic [MeanW-1:0]  mean_q [NumChan];
  logic [VarW-1:0]   var_q  [NumChan];

  stat_result_t pending_stats [$];

  // Welford update of one channel, returns the reported statistics
  function automatic stat_result_t update_stats(logic [3:0] ch, logic rs, logic [31:0] x);
    stat_result_t r;
    logic [47:0]  xq, mo, mn, a1, a2;
    logic [31:0]  n;
    logic [127:0] prod, acc, quo;
    if (rs) begin
      cnt_q[ch] = '0; min_q[ch] = '0; max_q[ch] = '0; mean_q[ch] = '0; var_q[ch] = '0;
    end
    if (cnt_q[ch] == '0) begin
      min_q[ch] = x;
      max_q[ch] = x;
    end else begin
      if (x < min_q[ch]) min_q[ch] = x;
      if (x > max_q[ch]) max_q[ch] = x;
    end
    if (cnt_q[ch] != CountMax) cnt_q[ch] = cnt_q[ch] + 32'd1;
    n  = cnt_q[ch];
    xq = {x, 16'h0};
    mo = mean_q[ch];
    if (xq >= mo) begin
      a1 = xq - mo;
      mn = mo + a1 / {16'h0, n};
      a2 = xq - mn;
    end else begin
      a1 = mo - xq;
      mn = mo - a1 / {16'h0, n};
      a2 = mn - xq;
    end
    prod = ({80'h0, a1} * {80'h0, a2}) >> 32;
    acc  = {96'h0, n - 32'd1} * {64'h0, var_q[ch]} + prod;
    quo  = acc / {96'h0, n};
    mean_q[ch] = mn;
    var_q[ch]  = (quo[127:64] != '0) ? '1 : quo[63:0];
    r.ch    = ch;
    r.count = cnt_q[ch];
    r.min_v = min_q[ch];
    r.max_v = max_q[ch];
    r.mean  = mean_q[ch];
    r.var_v = var_q[ch];
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // directed rows: first samples of a series and some repeats are typed in, the rest predicted
  stim_row_t directed [18] = '{
    '{4'd0,  1'b0, 32'h0000_0000, 1'b1, '{4'd0, 32'd1, 32'h0, 32'h0, 48'h0, 64'h0}},
    '{4'd0,  1'b0, 32'hFFFF_FFFF, 1'b0, '0},
    '{4'd0,  1'b0, 32'h0000_0000, 1'b0, '0},
    '{4'd1,  1'b1, 32'hFFFF_FFFF, 1'b1,
      '{4'd1, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_0000, 64'h0}},
    '{4'd1,  1'b0, 32'hFFFF_FFFF, 1'b1,
      '{4'd1, 32'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_0000, 64'h0}},
    '{4'd1,  1'b0, 32'h0000_0000, 1'b0, '0},
    '{4'd0,  1'b1, 32'h0000_0100, 1'b1,
      '{4'd0, 32'd1, 32'h100, 32'h100, 48'h0000_0100_0000, 64'h0}},
    '{4'd15, 1'b0, 32'h1234_5678, 1'b1,
      '{4'd15, 32'd1, 32'h1234_5678, 32'h1234_5678, 48'h1234_5678_0000, 64'h0}},
    '{4'd15, 1'b0, 32'h1234_5678, 1'b1,
      '{4'd15, 32'd2, 32'h1234_5678, 32'h1234_5678, 48'h1234_5678_0000, 64'h0}},
    '{4'd15, 1'b1, 32'h0000_0001, 1'b1,
      '{4'd15, 32'd1, 32'h1, 32'h1, 48'h0000_0001_0000, 64'h0}},
    '{4'd15, 1'b0, 32'h0000_0003, 1'b0, '0},
    '{4'd15, 1'b0, 32'h8000_0000, 1'b0, '0},
    '{4'd7,  1'b0, 32'hAAAA_AAAA, 1'b1,
      '{4'd7, 32'd1, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 48'hAAAA_AAAA_0000, 64'h0}},
    '{4'd7,  1'b0, 32'h5555_5555, 1'b0, '0},
    '{4'd7,  1'b1, 32'h5555_5555, 1'b1,
      '{4'd7, 32'd1, 32'h5555_5555, 32'h5555_5555, 48'h5555_5555_0000, 64'h0}},
    '{4'd7,  1'b0, 32'hFFFF_FFFF, 1'b0, '0},
    '{4'd7,  1'b0, 32'h0000_0000, 1'b0, '0},
    '{4'd8,  1'b1, 32'h0000_0000, 1'b1, '{4'd8, 32'd1, 32'h0, 32'h0, 48'h0, 64'h0}}
  };

  // result side: random stalls, compare with the oldest expectation
  int stall = 0;
  always @(posedge clk) begin
    if (rst) begin
      result_out.ready <= 1'b0;
    end else begin
      if (result_out.valid && result_out.ready) begin
        if (pending_stats.size() == 0) begin
          $display("unexpected transaction on channel %0d at %0t",
                   result_out.out_channel, $realtime);
          errors++;
        end else begin
          stat_result_t e;
          e = pending_stats.pop_front();
          if (result_out.out_channel != e.ch) report("channel", result_out.out_channel, e.ch);
          if (result_out.sample_count != e.count) report("count", result_out.sample_count, e.count);
          if (result_out.min_value != e.min_v) report("min", result_out.min_value, e.min_v);
          if (result_out.max_value != e.max_v) report("max", result_out.max_value, e.max_v);
          if (result_out.mean_value != e.mean) report("mean", result_out.mean_value, e.mean);
          if (result_out.variance_value != e.var_v)
            report("variance", result_out.variance_value, e.var_v);
        end
        stall = calm ? 0 : $urandom_range(0, 18);
      end
      if (stall > 0) begin
        result_out.ready <= 1'b0;
        stall--;
      end else begin
        result_out.ready <= 1'b1;
      end
    end
  end

  // sample side
  initial begin
    stat_result_t r;
    logic [3:0]   ch;
    logic         rs;
    logic [31:0]  x;
    int           gap;
    int           total;
    sample_in.valid        = 1'b0;
    sample_in.channel      = '0;
    sample_in.restart      = 1'b0;
    sample_in.sample_value = '0;
    for (int c = 0; c < NumChan; c++) begin
      cnt_q[c] = '0; min_q[c] = '0; max_q[c] = '0; mean_q[c] = '0; var_q[c] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    total = $size(directed) + RandItems;
    for (int i = 0; i < total; i++) begin
      calm = (i % 300) < 40;
      if (i < $size(directed)) begin
        ch = directed[i].ch; rs = directed[i].rs; x = directed[i].x;
      end else begin
        ch = ((i / 150) % 2 == 1) ? 4'($urandom_range(0, 2)) : 4'($urandom_range(0, 15));
        rs = ($urandom_range(0, 99) < 4);
        case ($urandom_range(0, 7))
          0:       x = 32'h0;
          1:       x = 32'hFFFF_FFFF;
          2:       x = $urandom_range(0, 255);
          3:       x = 32'h8000_0000 ^ $urandom_range(0, 65535);
          default: x = $urandom;
        endcase
      end
      // hold off once until the core has drained
      if (i == total / 2) begin
        sample_in.valid <= 1'b0;
        while (pending_stats.size() != 0) @(posedge clk);
      end
      gap = calm ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        sample_in.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      sample_in.valid        <= 1'b1;
      sample_in.channel      <= ch;
      sample_in.restart      <= rs;
      sample_in.sample_value <= x;
      do @(posedge clk); while (!sample_in.ready);
      r = update_stats(ch, rs, x);
      if (i < $size(directed) && directed[i].typed) r = directed[i].exp;
      pending_stats.push_back(r);
    end
    sample_in.valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (errors == 0 && pending_stats.size() == 0) begin
      $display("** running_min_max_mean_variance_core: PASSED **");
    end else begin
      $display("** running_min_max_mean_variance_core: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #30ms;
    $display("timeout with %0d results outstanding", pending_stats.size());
    $display("** running_min_max_mean_variance_core: FAILED **");
    $finish;
  end

endmodule
